### rtl/lqr_pkg.sv
// shared types and constants for the lqr state-feedback law block
// no dependencies; the rtl and testbench files that use it refer to it by scoped names
package lqr_pkg;

   // widest control index the command port can carry (up to 16 controls)
   localparam int K_W = 4;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   typedef enum logic [1:0] {
      ACT_GAIN  = 2'd0,
      ACT_REF   = 2'd1,
      ACT_STATE = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      REG_N_STATES   = 2'd0,
      REG_N_CONTROLS = 2'd1,
      REG_OUTPUT_MIN = 2'd2,
      REG_OUTPUT_MAX = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERR,
      ST_MAC,
      ST_DRAIN,
      ST_PRIM,
      ST_CLAMP,
      ST_EMIT,
      ST_ZERO
   } state_type;

   // effective configuration, counts already limited to the build sizes
   typedef struct packed {
      logic [4:0]         ns;
      logic [2:0]         nc;
      logic signed [31:0] out_min;
      logic signed [31:0] out_max;
   } cfg_type;

   typedef struct packed {
      logic           issue;
      logic           err_load;
      logic           prim_load;
      logic           clamp_load;
      logic           emit_load;
      logic           emit_zero;
      logic           emit_last;
      logic           end_run;
      logic [K_W-1:0] k;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic item_last;
      logic busy;
      logic rsp_free;
      logic gain_flag;
   } status_type;

endpackage

### rtl/lqr_req_if.sv
// request channel: valid/ready handshake with one input item
// depends on nothing but plain logic types
interface lqr_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic [1:0]         row;
   logic [3:0]         col;
   logic signed [31:0] value;
   logic               last;

   modport source (output valid, output action, output row, output col,
                   output value, output last, input ready);
   modport sink   (input valid, input action, input row, input col,
                   input value, input last, output ready);
endinterface

### rtl/lqr_rsp_if.sv
// result channel: valid/ready handshake with one control result
// depends on nothing but plain logic types
interface lqr_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         control_index;
   logic signed [31:0] control_value;
   logic signed [31:0] primary_clamped;
   logic signed [31:0] first_error;
   logic               gain_ready;
   logic               last_result;

   modport source (output valid, output control_index, output control_value,
                   output primary_clamped, output first_error, output gain_ready,
                   output last_result, input ready);
   modport sink   (input valid, input control_index, input control_value,
                   input primary_clamped, input first_error, input gain_ready,
                   input last_result, output ready);
endinterface

### rtl/lqr_state_feedback_law_top.sv
// lqr state-feedback law u = -K(x - xref), signed q16.16, one shared 32x32 multiplier
// gain, reference and clear requests are taken while idle; a state element has an error step,
// then, if in range with controls in use, one issue per control and a drain; the final element
// adds primary and clamp steps, then one result per cycle as taken; not ready: a single zero result
// synchronous reset clears the counts, sets the limits to full range, and clears the reference store,
// accumulators and the gain-ready flag; the gain memory is not cleared and holds whatever was last written
module lqr_state_feedback_law_top #(
   parameter int STATE_MAX   = 16,
   parameter int CONTROL_MAX = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready,
   lqr_req_if.sink      req_chan,
   lqr_rsp_if.source    rsp_chan
);

   lqr_pkg::cfg_type    cfg;
   lqr_pkg::cmd_type    cmd;
   lqr_pkg::status_type st;
   logic                req_ready;
   logic                req_accept;

   assign req_chan.ready = req_ready;
   assign req_accept     = req_chan.valid && req_ready;

   lqr_csr #(
      .STATE_MAX   (STATE_MAX),
      .CONTROL_MAX (CONTROL_MAX)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lqr_ctrl #(
      .CONTROL_MAX (CONTROL_MAX)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_ready),
      .cfg        (cfg),
      .st         (st),
      .cmd        (cmd)
   );

   lqr_dp #(
      .STATE_MAX   (STATE_MAX),
      .CONTROL_MAX (CONTROL_MAX)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .req_accept          (req_accept),
      .req_action          (req_chan.action),
      .req_row             (req_chan.row),
      .req_col             (req_chan.col),
      .req_value           (req_chan.value),
      .req_last            (req_chan.last),
      .rsp_ready           (rsp_chan.ready),
      .rsp_valid           (rsp_chan.valid),
      .rsp_control_index   (rsp_chan.control_index),
      .rsp_control_value   (rsp_chan.control_value),
      .rsp_primary_clamped (rsp_chan.primary_clamped),
      .rsp_first_error     (rsp_chan.first_error),
      .rsp_gain_ready      (rsp_chan.gain_ready),
      .rsp_last_result     (rsp_chan.last_result),
      .cfg                 (cfg),
      .cmd                 (cmd),
      .st                  (st)
   );

endmodule

### rtl/lqr_csr.sv
// apb-style configuration registers and effective count limiting
// depends on lqr_pkg
module lqr_csr #(
   parameter int STATE_MAX   = 16,
   parameter int CONTROL_MAX = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [3:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output lqr_pkg::cfg_type     cfg
);

   logic [4:0]         n_states_ff;
   logic [2:0]         n_controls_ff;
   logic signed [31:0] out_min_ff;
   logic signed [31:0] out_max_ff;
   logic               wr_en;
   lqr_pkg::reg_index_type idx;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign idx   = lqr_pkg::reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         n_states_ff   <= '0;
         n_controls_ff <= '0;
         out_min_ff    <= lqr_pkg::Q_MIN;
         out_max_ff    <= lqr_pkg::Q_MAX;
      end else if (wr_en) begin
         case (idx)
            lqr_pkg::REG_N_STATES:   n_states_ff   <= csr_pwdata[4:0];
            lqr_pkg::REG_N_CONTROLS: n_controls_ff <= csr_pwdata[2:0];
            lqr_pkg::REG_OUTPUT_MIN: out_min_ff    <= $signed(csr_pwdata);
            lqr_pkg::REG_OUTPUT_MAX: out_max_ff    <= $signed(csr_pwdata);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         lqr_pkg::REG_N_STATES:   csr_prdata = {27'd0, n_states_ff};
         lqr_pkg::REG_N_CONTROLS: csr_prdata = {29'd0, n_controls_ff};
         lqr_pkg::REG_OUTPUT_MIN: csr_prdata = out_min_ff;
         lqr_pkg::REG_OUTPUT_MAX: csr_prdata = out_max_ff;
         default:                 csr_prdata = '0;
      endcase
   end

   // counts above the build sizes act as the build sizes
   always_comb begin
      cfg.ns = (32'(n_states_ff) > 32'(STATE_MAX)) ? 5'(STATE_MAX) : n_states_ff;
      cfg.nc = (32'(n_controls_ff) > 32'(CONTROL_MAX)) ? 3'(CONTROL_MAX) : n_controls_ff;
      cfg.out_min = out_min_ff;
      cfg.out_max = out_max_ff;
   end

endmodule

### rtl/lqr_ctrl.sv
// controller state machine: sequences error, multiply-accumulate and result steps
// depends on lqr_pkg; drives the datapath through cmd_type only
module lqr_ctrl #(
   parameter int CONTROL_MAX = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_action,
   output logic                  req_ready,
   input  lqr_pkg::cfg_type      cfg,
   input  lqr_pkg::status_type   st,
   output lqr_pkg::cmd_type      cmd
);

   localparam int KW = (CONTROL_MAX > 1) ? $clog2(CONTROL_MAX) : 1;

   lqr_pkg::state_type state_ff, state_in;
   logic [KW-1:0]      k_ff, k_in;
   logic [2:0]         count;
   logic               k_done;
   logic               emit_done;
   lqr_pkg::state_type fin_state;

   assign count     = (cfg.nc == 3'd0) ? 3'd1 : cfg.nc;
   assign k_done    = (32'(k_ff) + 32'd1) == 32'(cfg.nc);
   assign emit_done = (32'(k_ff) + 32'd1) == 32'(count);
   // end of run: real results only with a loaded gain and some states in use
   assign fin_state = (st.gain_flag && cfg.ns != 5'd0) ? lqr_pkg::ST_PRIM
                                                       : lqr_pkg::ST_ZERO;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lqr_pkg::ST_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      k_in     = '0;
      case (state_ff)
         lqr_pkg::ST_IDLE: begin
            if (req_valid && req_action == lqr_pkg::ACT_STATE) state_in = lqr_pkg::ST_ERR;
         end
         lqr_pkg::ST_ERR: begin
            if (st.hit && cfg.nc != 3'd0) state_in = lqr_pkg::ST_MAC;
            else if (st.item_last)        state_in = fin_state;
            else                          state_in = lqr_pkg::ST_IDLE;
         end
         lqr_pkg::ST_MAC: begin
            k_in = KW'(k_ff + 1'b1);
            if (k_done) state_in = lqr_pkg::ST_DRAIN;
         end
         lqr_pkg::ST_DRAIN: begin
            if (!st.busy) state_in = st.item_last ? fin_state : lqr_pkg::ST_IDLE;
         end
         lqr_pkg::ST_PRIM:  state_in = lqr_pkg::ST_CLAMP;
         lqr_pkg::ST_CLAMP: state_in = lqr_pkg::ST_EMIT;
         lqr_pkg::ST_EMIT: begin
            k_in = k_ff;
            if (st.rsp_free) begin
               k_in = KW'(k_ff + 1'b1);
               if (emit_done) state_in = lqr_pkg::ST_IDLE;
            end
         end
         lqr_pkg::ST_ZERO: begin
            if (st.rsp_free) state_in = lqr_pkg::ST_IDLE;
         end
         default: state_in = lqr_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      cmd.k     = lqr_pkg::K_W'(k_ff);
      req_ready = 1'b0;
      case (state_ff)
         lqr_pkg::ST_IDLE:  req_ready = 1'b1;
         lqr_pkg::ST_ERR:   cmd.err_load = 1'b1;
         lqr_pkg::ST_MAC:   cmd.issue = 1'b1;
         lqr_pkg::ST_DRAIN: ;
         lqr_pkg::ST_PRIM:  cmd.prim_load = 1'b1;
         lqr_pkg::ST_CLAMP: cmd.clamp_load = 1'b1;
         lqr_pkg::ST_EMIT: begin
            if (st.rsp_free) begin
               cmd.emit_load = 1'b1;
               cmd.emit_last = emit_done;
               cmd.end_run   = emit_done;
            end
         end
         lqr_pkg::ST_ZERO: begin
            if (st.rsp_free) begin
               cmd.emit_zero = 1'b1;
               cmd.end_run   = 1'b1;
            end
         end
         default: ;
      endcase
   end

endmodule

### rtl/lqr_dp.sv
// datapath: gain memory, reference store, error, shared multiplier, accumulators
// and the result register; depends on lqr_pkg, driven by lqr_ctrl commands
module lqr_dp #(
   parameter int STATE_MAX   = 16,
   parameter int CONTROL_MAX = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_accept,
   input  logic [1:0]            req_action,
   input  logic [1:0]            req_row,
   input  logic [3:0]            req_col,
   input  logic signed [31:0]    req_value,
   input  logic                  req_last,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_control_index,
   output logic signed [31:0]    rsp_control_value,
   output logic signed [31:0]    rsp_primary_clamped,
   output logic signed [31:0]    rsp_first_error,
   output logic                  rsp_gain_ready,
   output logic                  rsp_last_result,
   input  lqr_pkg::cfg_type      cfg,
   input  lqr_pkg::cmd_type      cmd,
   output lqr_pkg::status_type   st
);

   localparam int SW     = (STATE_MAX > 1) ? $clog2(STATE_MAX) : 1;
   localparam int KW     = (CONTROL_MAX > 1) ? $clog2(CONTROL_MAX) : 1;
   localparam int XW     = (SW > 4) ? SW : 4;
   localparam int GDEPTH = STATE_MAX * CONTROL_MAX;
   localparam int GW     = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;

   function automatic logic signed [31:0] sat33(input logic signed [32:0] d);
      if (d[32] == d[31]) return d[31:0];
      return d[32] ? lqr_pkg::Q_MIN : lqr_pkg::Q_MAX;
   endfunction

   // -(acc >>> 16) limited to 32 bits
   function automatic logic signed [31:0] ctrl_from_acc(input logic [63:0] acc);
      logic signed [48:0] neg;
      neg = -$signed({acc[63], acc[63:16]});
      if (neg[48:31] == {18{neg[48]}}) return neg[31:0];
      return neg[48] ? lqr_pkg::Q_MIN : lqr_pkg::Q_MAX;
   endfunction

   logic signed [31:0] gain_mem [GDEPTH];
   logic signed [31:0] ref_ff [STATE_MAX];
   logic [63:0]        acc_ff [CONTROL_MAX];

   logic               gain_flag_ff;
   logic [3:0]         item_col_ff;
   logic signed [31:0] item_value_ff;
   logic               item_last_ff;
   logic signed [31:0] err_ff, err_in;
   logic signed [31:0] first_err_ff;
   logic signed [31:0] gain_rd_ff;
   logic               s1_valid_ff, s2_valid_ff;
   logic [KW-1:0]      s1_k_ff, s2_k_ff;
   logic signed [63:0] prod_ff;
   logic signed [31:0] prim_ff, prim_in;
   logic signed [31:0] clamp_ff, clamp_in;

   logic               rsp_valid_ff;
   logic [1:0]         rsp_index_ff;
   logic signed [31:0] rsp_value_ff, rsp_prim_ff, rsp_first_ff;
   logic               rsp_gready_ff, rsp_last_ff;

   logic [XW-1:0]      req_colx, item_colx;
   logic [SW-1:0]      req_idx, item_idx;
   logic [KW-1:0]      cmd_k, acc_idx;
   logic [KW+1:0]      cmd_kx;
   logic               gain_we, ref_we, ref_clear;
   logic [GW-1:0]      gain_waddr, gain_raddr;
   logic signed [31:0] ref_rd;
   logic [63:0]        acc_rd;
   logic signed [31:0] ctrl_val;
   logic               nc_zero;

   assign req_colx  = XW'(req_col);
   assign item_colx = XW'(item_col_ff);
   assign req_idx   = req_colx[SW-1:0];
   assign item_idx  = item_colx[SW-1:0];
   assign cmd_k     = cmd.k[KW-1:0];
   assign cmd_kx    = (KW+2)'(cmd_k);
   assign nc_zero   = (cfg.nc == 3'd0);

   assign gain_we = req_accept && req_action == lqr_pkg::ACT_GAIN
                 && 32'(req_row) < 32'(CONTROL_MAX) && 32'(req_col) < 32'(STATE_MAX);
   assign ref_we  = req_accept && req_action == lqr_pkg::ACT_REF
                 && 32'(req_col) < 32'(STATE_MAX);
   assign ref_clear  = req_accept && req_action == lqr_pkg::ACT_CLEAR;
   assign gain_waddr = GW'(32'(req_row) * STATE_MAX + 32'(req_col));
   assign gain_raddr = GW'(32'(cmd_k) * STATE_MAX + 32'(item_col_ff));

   // gain memory, registered read
   always_ff @(posedge clock) begin
      if (gain_we) gain_mem[gain_waddr] <= req_value;
      if (cmd.issue) gain_rd_ff <= gain_mem[gain_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset || ref_clear) begin
         for (int i = 0; i < STATE_MAX; i++) ref_ff[i] <= '0;
      end else if (ref_we) begin
         ref_ff[req_idx] <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) gain_flag_ff <= 1'b0;
      else if (req_accept && req_action == lqr_pkg::ACT_GAIN && req_last) gain_flag_ff <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_col_ff   <= req_col;
         item_value_ff <= req_value;
         item_last_ff  <= req_last;
      end
   end

   assign ref_rd = ref_ff[item_idx];
   assign err_in = sat33({item_value_ff[31], item_value_ff} - {ref_rd[31], ref_rd});

   always_ff @(posedge clock) begin
      if (cmd.err_load) err_ff <= err_in;
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.end_run) first_err_ff <= '0;
      else if (cmd.err_load && st.hit && item_col_ff == 4'd0) first_err_ff <= err_in;
   end

   // read, multiply and accumulate stages, one control per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_k_ff <= cmd_k;
      s2_k_ff <= s1_k_ff;
      prod_ff <= gain_rd_ff * err_ff;
   end

   // one accumulator read port, shared by the add stage and the result steps
   assign acc_idx = s2_valid_ff ? s2_k_ff : cmd_k;
   assign acc_rd  = acc_ff[acc_idx];

   always_ff @(posedge clock) begin
      if (reset || cmd.end_run) begin
         for (int i = 0; i < CONTROL_MAX; i++) acc_ff[i] <= '0;
      end else if (s2_valid_ff) begin
         acc_ff[s2_k_ff] <= acc_rd + prod_ff;
      end
   end

   assign ctrl_val = nc_zero ? 32'sd0 : ctrl_from_acc(acc_rd);
   assign prim_in  = ctrl_val;
   // lower limit is tested first
   assign clamp_in = (prim_ff < cfg.out_min) ? cfg.out_min :
                     (prim_ff > cfg.out_max) ? cfg.out_max : prim_ff;

   always_ff @(posedge clock) begin
      if (cmd.prim_load)  prim_ff  <= prim_in;
      if (cmd.clamp_load) clamp_ff <= clamp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.emit_load || cmd.emit_zero) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_zero) begin
         rsp_index_ff  <= '0;
         rsp_value_ff  <= '0;
         rsp_prim_ff   <= '0;
         rsp_first_ff  <= '0;
         rsp_gready_ff <= 1'b0;
         rsp_last_ff   <= 1'b1;
      end else if (cmd.emit_load) begin
         rsp_index_ff  <= cmd_kx[1:0];
         rsp_value_ff  <= ctrl_val;
         rsp_prim_ff   <= clamp_ff;
         rsp_first_ff  <= first_err_ff;
         rsp_gready_ff <= 1'b1;
         rsp_last_ff   <= cmd.emit_last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_control_index   = rsp_index_ff;
   assign rsp_control_value   = rsp_value_ff;
   assign rsp_primary_clamped = rsp_prim_ff;
   assign rsp_first_error     = rsp_first_ff;
   assign rsp_gain_ready      = rsp_gready_ff;
   assign rsp_last_result     = rsp_last_ff;

   always_comb begin
      st.hit       = 32'(item_col_ff) < 32'(cfg.ns);
      st.item_last = item_last_ff;
      st.busy      = s1_valid_ff || s2_valid_ff;
      st.rsp_free  = !rsp_valid_ff || rsp_ready;
      st.gain_flag = gain_flag_ff;
   end

`ifndef SYNTHESIS
   a_emit_after_drain: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_load || cmd.prim_load) |-> (!s1_valid_ff && !s2_valid_ff))
      else $error("result step while multiply-accumulate still in flight");
   a_issue_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> st.hit)
      else $error("multiply issued for a state element out of range");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_load || cmd.emit_zero) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before it was taken");
   a_run_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.end_run |=> (first_err_ff == '0 && acc_ff[0] == '0))
      else $error("run state not cleared after the last result");
`endif

endmodule

### tb/lqr_state_feedback_law_top_tb.sv
`timescale 1ns / 100ps
// testbench for lqr_state_feedback_law_top: random requests against an in-bench control-law predictor
// depends on lqr_pkg, lqr_req_if, lqr_rsp_if and the top-level rtl
module lqr_state_feedback_law_top_tb;

   typedef struct {
      lqr_pkg::action_type action;
      logic [1:0]          row;
      logic [3:0]          col;
      logic signed [31:0]  value;
      logic                last;
   } request_type;

   typedef struct {
      logic [1:0]         control_index;
      logic signed [31:0] control_value;
      logic signed [31:0] primary_clamped;
      logic signed [31:0] first_error;
      logic               gain_ready;
      logic               last_result;
   } control_result_type;

   class control_scoreboard;
      logic signed [31:0] gain [4][16];
      logic signed [31:0] ref_table [16];
      logic signed [63:0] acc [4];
      logic signed [31:0] first_err;
      bit                 gain_loaded;
      logic [4:0]         n_states;
      logic [2:0]         n_controls;
      logic signed [31:0] out_min;
      logic signed [31:0] out_max;
      control_result_type expected_q [$];
      int                 error_count;

      function new();
         foreach (gain[k, s]) gain[k][s] = '0;
         foreach (ref_table[s]) ref_table[s] = '0;
         foreach (acc[k]) acc[k] = '0;
         first_err   = '0;
         gain_loaded = 1'b0;
         n_states    = '0;
         n_controls  = '0;
         out_min     = lqr_pkg::Q_MIN;
         out_max     = lqr_pkg::Q_MAX;
         error_count = 0;
      endfunction

      function logic signed [31:0] sat32(longint v);
         if (v > longint'(lqr_pkg::Q_MAX)) return lqr_pkg::Q_MAX;
         if (v < longint'(lqr_pkg::Q_MIN)) return lqr_pkg::Q_MIN;
         return v[31:0];
      endfunction

      function void set_register(lqr_pkg::reg_index_type idx, logic [31:0] data);
         case (idx)
            lqr_pkg::REG_N_STATES:   n_states   = data[4:0];
            lqr_pkg::REG_N_CONTROLS: n_controls = data[2:0];
            lqr_pkg::REG_OUTPUT_MIN: out_min    = data;
            lqr_pkg::REG_OUTPUT_MAX: out_max    = data;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_request(request_type r);
         int                 ns_eff;
         int                 nc_eff;
         int                 count;
         int                 k;
         longint             err;
         longint             u;
         longint             u0;
         longint             clamped;
         control_result_type res;
         ns_eff = (int'(n_states) > 16) ? 16 : int'(n_states);
         nc_eff = (int'(n_controls) > 4) ? 4 : int'(n_controls);
         case (r.action)
            lqr_pkg::ACT_GAIN: begin
               gain[r.row][r.col] = r.value;
               if (r.last) gain_loaded = 1'b1;
            end
            lqr_pkg::ACT_REF: ref_table[r.col] = r.value;
            lqr_pkg::ACT_CLEAR: foreach (ref_table[s]) ref_table[s] = '0;
            lqr_pkg::ACT_STATE: begin
               if (int'(r.col) < ns_eff) begin
                  err = longint'(sat32(longint'(r.value) - longint'(ref_table[r.col])));
                  if (r.col == 0) first_err = err[31:0];
                  // every control row accumulates, even the ones not in use
                  for (k = 0; k < 4; k++)
                     acc[k] = acc[k] + longint'(gain[k][r.col]) * err;
               end
               if (r.last) begin
                  if (!gain_loaded || ns_eff == 0) begin
                     res.control_index   = '0;
                     res.control_value   = '0;
                     res.primary_clamped = '0;
                     res.first_error     = '0;
                     res.gain_ready      = 1'b0;
                     res.last_result     = 1'b1;
                     expected_q.push_back(res);
                  end else begin
                     if (nc_eff > 0) u0 = longint'(sat32(-(acc[0] >>> 16)));
                     else u0 = 0;
                     // lower limit is tested first; when the limits cross, values not below it take the upper limit
                     clamped = u0;
                     if (u0 < longint'(out_min)) clamped = longint'(out_min);
                     else if (u0 > longint'(out_max)) clamped = longint'(out_max);
                     count = (nc_eff > 0) ? nc_eff : 1;
                     for (k = 0; k < count; k++) begin
                        if (nc_eff > 0) u = longint'(sat32(-(acc[k] >>> 16)));
                        else u = 0;
                        res.control_index   = k[1:0];
                        res.control_value   = u[31:0];
                        res.primary_clamped = clamped[31:0];
                        res.first_error     = first_err;
                        res.gain_ready      = 1'b1;
                        res.last_result     = (k + 1 == count);
                        expected_q.push_back(res);
                     end
                  end
                  foreach (acc[j]) acc[j] = '0;
                  first_err = '0;
               end
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
         end
      endfunction

      function void check_result(control_result_type got);
         control_result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: result with nothing expected, control %0d value %0h",
                     $time, got.control_index, got.control_value);
            error_count++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("control_index", 32'(want.control_index), 32'(got.control_index));
         compare_field("control_value", want.control_value, got.control_value);
         compare_field("primary_clamped", want.primary_clamped, got.primary_clamped);
         compare_field("first_error", want.first_error, got.first_error);
         compare_field("gain_ready", 32'(want.gain_ready), 32'(got.gain_ready));
         compare_field("last_result", 32'(want.last_result), 32'(got.last_result));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   bit          idle_on = 1'b1;

   control_scoreboard sb = new();

   lqr_req_if req_bus ();
   lqr_rsp_if rsp_bus ();

   lqr_state_feedback_law_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin : watchdog
      #5000000;
      $display("Test completed with failures");
      $finish;
   end

   // mostly small values, with extremes and full-width patterns mixed in
   function automatic logic signed [31:0] rand_value();
      case ($urandom_range(0, 9))
         0: return lqr_pkg::Q_MAX;
         1: return lqr_pkg::Q_MIN;
         2: return '0;
         3, 4: return $urandom;
         default: return int'($urandom_range(0, 524288)) - 262144;
      endcase
   endfunction

   task automatic write_csr(lqr_pkg::reg_index_type idx, logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_register(idx, data);
      @(posedge clock);
   endtask

   task automatic send_request(lqr_pkg::action_type act, logic [1:0] row, logic [3:0] col,
                               logic signed [31:0] value, logic last);
      request_type item;
      item.action = act;
      item.row    = row;
      item.col    = col;
      item.value  = value;
      item.last   = last;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.action <= act;
      req_bus.row    <= row;
      req_bus.col    <= col;
      req_bus.value  <= value;
      req_bus.last   <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_request(item);
   endtask

   // one well-formed pass over the states in use, last on the final element; a lone last element when none
   task automatic run_states(int n);
      int s;
      if (n == 0) begin
         send_request(lqr_pkg::ACT_STATE, 2'($urandom_range(0, 3)),
                      4'($urandom_range(0, 15)), rand_value(), 1'b1);
      end else begin
         for (s = 0; s < n; s++)
            send_request(lqr_pkg::ACT_STATE, 2'($urandom_range(0, 3)), 4'(s), rand_value(),
                         s == n - 1);
      end
   endtask

   // stop requesting, wait for outstanding results, then let the block go idle
   task automatic settle();
      int guard;
      guard = 0;
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);
   endtask

   task automatic random_phase(int n_items);
      int                 ns_cfg;
      int                 nc_cfg;
      int                 ns_eff;
      int                 pick;
      int                 sent;
      int                 span;
      logic signed [31:0] lo;
      logic signed [31:0] hi;
      pick = $urandom_range(0, 9);
      if (pick < 7) ns_cfg = $urandom_range(1, 16);
      else if (pick < 8) ns_cfg = 0;
      else ns_cfg = $urandom_range(17, 31);
      nc_cfg = $urandom_range(0, 7);
      span = $urandom_range(1, 1 << 20);
      case ($urandom_range(0, 3))
         0: begin
            lo = lqr_pkg::Q_MIN;
            hi = lqr_pkg::Q_MAX;
         end
         1: begin
            lo = -span;
            hi = span;
         end
         2: begin
            // crossed limits
            lo = span;
            hi = -span;
         end
         default: begin
            lo = $urandom;
            hi = $urandom;
         end
      endcase
      settle();
      write_csr(lqr_pkg::REG_N_STATES, ns_cfg);
      write_csr(lqr_pkg::REG_N_CONTROLS, nc_cfg);
      write_csr(lqr_pkg::REG_OUTPUT_MIN, lo);
      write_csr(lqr_pkg::REG_OUTPUT_MAX, hi);
      ns_eff = (ns_cfg > 16) ? 16 : ns_cfg;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            run_states(ns_eff);
            sent += (ns_eff > 0) ? ns_eff : 1;
         end else begin
            if (pick < 70)
               send_request(lqr_pkg::ACT_GAIN, 2'($urandom_range(0, 3)),
                            4'($urandom_range(0, 15)), rand_value(),
                            1'($urandom_range(0, 1)));
            else if (pick < 78)
               send_request(lqr_pkg::ACT_REF, 2'($urandom_range(0, 3)),
                            4'($urandom_range(0, 15)), rand_value(),
                            1'($urandom_range(0, 1)));
            else if (pick < 81)
               send_request(lqr_pkg::ACT_CLEAR, 2'($urandom_range(0, 3)),
                            4'($urandom_range(0, 15)), rand_value(),
                            1'($urandom_range(0, 1)));
            else
               // stray element, sometimes cutting the run short
               send_request(lqr_pkg::ACT_STATE, 2'($urandom_range(0, 3)),
                            4'($urandom_range(0, 15)), rand_value(),
                            $urandom_range(0, 7) == 0);
            sent++;
         end
      end
      // close any open run so the next setting starts clean
      send_request(lqr_pkg::ACT_STATE, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                   rand_value(), 1'b1);
   endtask

   initial begin : result_side
      int                 stall;
      control_result_type got;
      stall = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.control_index   = rsp_bus.control_index;
            got.control_value   = rsp_bus.control_value;
            got.primary_clamped = rsp_bus.primary_clamped;
            got.first_error     = rsp_bus.first_error;
            got.gain_ready      = rsp_bus.gain_ready;
            got.last_result     = rsp_bus.last_result;
            sb.check_result(got);
         end
         if (stall > 0) begin
            stall--;
            rsp_bus.ready <= (stall == 0);
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            stall = $urandom_range(1, 13);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int r;
      int c;
      reset          <= 1'b1;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      req_bus.valid  <= 1'b0;
      req_bus.action <= lqr_pkg::ACT_GAIN;
      req_bus.row    <= '0;
      req_bus.col    <= '0;
      req_bus.value  <= '0;
      req_bus.last   <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no states in use after reset, so the run ends not ready
      send_request(lqr_pkg::ACT_STATE, 2'd0, 4'd0, 32'sd5, 1'b1);

      // fill the whole gain matrix without marking it complete
      for (r = 0; r < 4; r++)
         for (c = 0; c < 16; c++)
            send_request(lqr_pkg::ACT_GAIN, 2'(r), 4'(c),
                         (c == 0 && r == 0) ? lqr_pkg::Q_MIN :
                         (c == 0 && r == 1) ? lqr_pkg::Q_MAX : rand_value(),
                         1'b0);
      settle();
      write_csr(lqr_pkg::REG_N_STATES, 32'd3);
      write_csr(lqr_pkg::REG_N_CONTROLS, 32'd2);
      run_states(3);

      send_request(lqr_pkg::ACT_GAIN, 2'd2, 4'd5, rand_value(), 1'b1);
      // error saturates high on element zero and low on element one
      send_request(lqr_pkg::ACT_REF, 2'd0, 4'd0, lqr_pkg::Q_MIN, 1'b0);
      send_request(lqr_pkg::ACT_REF, 2'd0, 4'd1, lqr_pkg::Q_MAX, 1'b0);
      send_request(lqr_pkg::ACT_STATE, 2'd0, 4'd0, lqr_pkg::Q_MAX, 1'b0);
      send_request(lqr_pkg::ACT_STATE, 2'd0, 4'd1, lqr_pkg::Q_MIN, 1'b0);
      send_request(lqr_pkg::ACT_STATE, 2'd0, 4'd2, 32'sd0, 1'b1);
      send_request(lqr_pkg::ACT_STATE, 2'd0, 4'd9, rand_value(), 1'b0);
      send_request(lqr_pkg::ACT_STATE, 2'd0, 4'd0, 32'sd65536, 1'b0);
      send_request(lqr_pkg::ACT_STATE, 2'd0, 4'd0, -32'sd65536, 1'b0);
      send_request(lqr_pkg::ACT_CLEAR, 2'd0, 4'd0, 32'sd0, 1'b0);
      send_request(lqr_pkg::ACT_STATE, 2'd0, 4'd2, 32'sd131072, 1'b1);

      // no controls: a single result with the clamp of zero
      settle();
      write_csr(lqr_pkg::REG_N_CONTROLS, 32'd0);
      write_csr(lqr_pkg::REG_OUTPUT_MIN, 32'd65536);
      write_csr(lqr_pkg::REG_OUTPUT_MAX, 32'd6553600);
      run_states(3);

      // counts above the build sizes, crossed limits
      settle();
      write_csr(lqr_pkg::REG_N_STATES, 32'd31);
      write_csr(lqr_pkg::REG_N_CONTROLS, 32'd7);
      write_csr(lqr_pkg::REG_OUTPUT_MIN, lqr_pkg::Q_MAX);
      write_csr(lqr_pkg::REG_OUTPUT_MAX, lqr_pkg::Q_MIN);
      run_states(16);

      repeat (5) random_phase(22);
      idle_on = 1'b0;
      random_phase(25);
      settle();

      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         if (sb.pending() != 0)
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
